// ----- hw/rtl/b64e_pkg.sv -----
// Package for the line-wrapped base64 encoder: job descriptor types, character
// constants and the alphabet lookup. No dependencies.
package b64e_pkg;

    localparam int unsigned QDEPTH_DEF = 4;
    localparam int unsigned QPL_RESET  = 18;
    localparam int unsigned APB_AW     = 3;

    localparam logic [7:0] CHAR_CR  = 8'd13;
    localparam logic [7:0] CHAR_LF  = 8'd10;
    localparam logic [7:0] CHAR_PAD = 8'd61;

    // register index, taken from paddr[2]
    localparam logic REG_QPL = 1'b0;

    typedef enum logic [1:0] {
        PH_EMPTY,
        PH_ONE,
        PH_TWO
    } t_phase;

    typedef enum logic [1:0] {
        QK_NONE,
        QK_FULL,
        QK_PAD1,
        QK_PAD2
    } t_quad;

    // one queued burst of characters: optional quad, optional CR LF
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        t_quad      quad;
        logic       crlf;
    } t_job;

    function automatic logic [7:0] b64_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'd65 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'd71 + {2'b00, v};          // 'a' - 26
        end else if (v < 6'd62) begin
            c = {2'b00, v} - 8'd4;           // '0' - 52
        end else if (v == 6'd62) begin
            c = 8'd43;                       // '+'
        end else begin
            c = 8'd47;                       // '/'
        end
        return c;
    endfunction

endpackage

// ----- hw/rtl/b64e_in_if.sv -----
// Input channel of the base64 encoder: one raw byte or a finish command per word.
// No dependencies.
interface b64e_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [7:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);
endinterface

// ----- hw/rtl/b64e_out_if.sv -----
// Output channel of the base64 encoder: one ASCII character per word.
// No dependencies.
interface b64e_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_char;
    logic       last_char;

    modport source (output valid, output out_char, output last_char, input ready);
    modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

// ----- hw/rtl/base64_line_wrapped_encoder.sv -----
// Line-wrapped base64 encoder, top level. A word that completes a triple or
// finishes goes into the job queue, then through the back end's character
// register. Throughput: one input word per cycle while the job queue has room;
// output one character per cycle while a job waits and the sink is ready.
// Reset (synchronous, active low) empties the queue and restores 18 quads per line.
module base64_line_wrapped_encoder
    import b64e_pkg::*;
#(
    parameter int unsigned QDEPTH = QDEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    b64e_in_if.sink           i_in,
    b64e_out_if.source        o_out,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [7:0] r_qpl;
    logic       w_push, w_full, w_pop, w_empty;
    t_job       w_job_in, w_job_out;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_QPL) ? {24'd0, r_qpl} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qpl <= 8'(QPL_RESET);
        end else if (psel && penable && pwrite && paddr[2] == REG_QPL) begin
            r_qpl <= pwdata[7:0];
        end
    end

    b64e_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in.valid),
        .o_ready     (i_in.ready),
        .i_command   (i_in.command),
        .i_data_byte (i_in.data_byte),
        .i_qpl       (r_qpl),
        .i_full      (w_full),
        .o_push      (w_push),
        .o_job       (w_job_in)
    );

    b64e_fifo #(.DEPTH(QDEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_job_in),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_job_out),
        .o_empty (w_empty)
    );

    b64e_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (w_job_out),
        .i_empty     (w_empty),
        .o_pop       (w_pop),
        .o_valid     (o_out.valid),
        .i_ready     (o_out.ready),
        .o_out_char  (o_out.out_char),
        .o_last_char (o_out.last_char)
    );

endmodule

// ----- hw/rtl/b64e_front.sv -----
// Front end: accepts input words, holds the partial triple, tracks the line
// count and queues a job per completed triple or finish. Uses b64e_pkg.
module b64e_front
    import b64e_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_command,
    input  logic [7:0] i_data_byte,
    input  logic [7:0] i_qpl,
    input  logic       i_full,
    output logic       o_push,
    output t_job       o_job
);

    t_phase     r_phase, n_phase;
    logic [7:0] r_first, r_second;
    logic [7:0] r_line, n_line;
    logic       w_accept;
    logic [8:0] w_next;
    logic       w_wrap;

    assign o_ready  = !i_full;
    assign w_accept = i_valid && !i_full;
    assign w_next   = {1'b0, r_line} + 9'd1;
    assign w_wrap   = w_next >= {1'b0, i_qpl};

    // next phase and line count
    always_comb begin
        n_phase = r_phase;
        n_line  = r_line;
        if (w_accept) begin
            if (i_command) begin
                n_phase = PH_EMPTY;
                n_line  = 8'd0;
            end else begin
                unique case (r_phase)
                    PH_ONE: n_phase = PH_TWO;
                    PH_TWO: begin
                        n_phase = PH_EMPTY;
                        n_line  = w_wrap ? 8'd0 : w_next[7:0];
                    end
                    default: n_phase = PH_ONE;
                endcase
            end
        end
    end

    // job build
    always_comb begin
        o_push    = 1'b0;
        o_job.b0  = r_first;
        o_job.b1  = r_second;
        o_job.b2  = i_data_byte;
        o_job.quad = QK_NONE;
        o_job.crlf = 1'b1;
        if (i_command) begin
            o_push   = w_accept;
            o_job.b2 = 8'd0;
            unique case (r_phase)
                PH_ONE: begin
                    o_job.quad = QK_PAD2;
                    o_job.b1   = 8'd0;
                end
                PH_TWO:  o_job.quad = QK_PAD1;
                default: o_job.quad = QK_NONE;
            endcase
        end else begin
            o_push     = w_accept && (r_phase == PH_TWO);
            o_job.quad = QK_FULL;
            o_job.crlf = w_wrap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_EMPTY;
            r_line  <= 8'd0;
        end else begin
            r_phase <= n_phase;
            r_line  <= n_line;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first  <= 8'd0;
            r_second <= 8'd0;
        end else if (w_accept && !i_command) begin
            if (r_phase == PH_ONE) begin
                r_second <= i_data_byte;
            end else if (r_phase != PH_TWO) begin
                r_first <= i_data_byte;
            end
        end
    end

endmodule

// ----- hw/rtl/b64e_fifo.sv -----
// Job queue between front and back end, register based, first word fall-through.
// Uses b64e_pkg.
module b64e_fifo
    import b64e_pkg::*;
#(
    parameter int unsigned DEPTH = QDEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    input  logic i_pop,
    output t_job o_data,
    output logic o_empty
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);

    t_job          r_mem [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;
    logic          w_wr, w_rd;

    assign o_full  = r_count == CW'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_data  = r_mem[r_rptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_wr) begin
                r_wptr <= (r_wptr == LAST_PTR) ? '0 : r_wptr + 1'b1;
            end
            if (w_rd) begin
                r_rptr <= (r_rptr == LAST_PTR) ? '0 : r_rptr + 1'b1;
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + 1'b1;
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/b64e_back.sv -----
// Back end: walks the job at the queue head into the output register, one
// character per cycle while that register is empty or taken. Uses b64e_pkg.
module b64e_back
    import b64e_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_job       i_job,
    input  logic       i_empty,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_char,
    output logic       o_last_char
);

    logic [2:0] r_pos;
    logic       r_valid;
    logic [7:0] r_char;
    logic       r_last;
    logic       w_adv, w_emit;
    logic [2:0] w_eff, w_end;
    logic       w_last;
    logic [7:0] w_char;
    logic [5:0] w_s0, w_s1, w_s2, w_s3;

    assign w_adv  = !r_valid || i_ready;
    assign w_emit = w_adv && !i_empty;
    // jobs without a quad start at the CR slot
    assign w_eff  = (i_job.quad == QK_NONE) ? r_pos + 3'd4 : r_pos;
    assign w_end  = i_job.crlf ? 3'd5 : 3'd3;
    assign w_last = w_eff == w_end;
    assign o_pop  = w_emit && w_last;

    assign w_s0 = i_job.b0[7:2];
    assign w_s1 = {i_job.b0[1:0], i_job.b1[7:4]};
    assign w_s2 = {i_job.b1[3:0], i_job.b2[7:6]};
    assign w_s3 = i_job.b2[5:0];

    always_comb begin
        unique case (w_eff)
            3'd0: w_char = b64_char(w_s0);
            3'd1: w_char = b64_char(w_s1);
            3'd2: w_char = (i_job.quad == QK_PAD2) ? CHAR_PAD : b64_char(w_s2);
            3'd3: w_char = (i_job.quad == QK_FULL) ? b64_char(w_s3) : CHAR_PAD;
            3'd4: w_char = CHAR_CR;
            default: w_char = CHAR_LF;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pos   <= 3'd0;
        end else if (w_emit) begin
            r_valid <= 1'b1;
            r_pos   <= w_last ? 3'd0 : r_pos + 3'd1;
        end else if (w_adv) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_char <= w_char;
            r_last <= w_last;
        end
    end

    assign o_valid     = r_valid;
    assign o_out_char  = r_char;
    assign o_last_char = r_last;

endmodule
